### rtl/core/llaa_pkg.sv
// Shared types and constants for the least-loaded area assigner.
// No dependencies; compiled first.
package llaa_pkg;

	localparam int MAX_WORKERS = 16;
	localparam int IDX_W       = $clog2(MAX_WORKERS);
	localparam int SIZE_W      = 48;
	localparam int LOAD_W      = 64;
	localparam int COUNT_W     = 5;
	localparam int WIDX_W      = 4;

	typedef logic [IDX_W-1:0]   idx_t;
	typedef logic [SIZE_W-1:0]  size_t;
	typedef logic [LOAD_W-1:0]  load_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [WIDX_W-1:0]  widx_t;

	localparam count_t COUNT_RESET = count_t'(1);

	// Controller to datapath command word
	typedef struct packed {
		logic load;     // capture the accepted area, clear totals on first_area
		logic rd_en;    // read one total for the minimum scan
		idx_t rd_addr;
		logic upd;      // write the new total back and load the result register
	} llaa_cmd_t;

endpackage

### rtl/core/llaa_if.sv
// Handshake channel interfaces: area requests, assignment results and the
// worker count write channel. Depends on llaa_pkg.
interface llaa_req_if;
	logic                valid;
	logic                ready;
	llaa_pkg::size_t     area_size;
	logic                first_area;

	modport source (output valid, output area_size, output first_area, input ready);
	modport sink   (input valid, input area_size, input first_area, output ready);
endinterface

interface llaa_rsp_if;
	logic                valid;
	logic                ready;
	llaa_pkg::widx_t     worker_index;
	llaa_pkg::load_t     worker_load;

	modport source (output valid, output worker_index, output worker_load, input ready);
	modport sink   (input valid, input worker_index, input worker_load, output ready);
endinterface

interface llaa_cfg_if;
	logic                valid;
	logic                ready;
	llaa_pkg::count_t    worker_count;

	modport source (output valid, output worker_count, input ready);
	modport sink   (input valid, input worker_count, output ready);
endinterface

### rtl/core/least_loaded_area_assigner_core.sv
// Top level of the least-loaded area assigner.
// Depends on llaa_pkg, llaa_if, llaa_ctrl and llaa_dp.

// Greedy load balancer over up to MAX_WORKERS (16) load totals. Each area
// transfer on req is assigned to the active worker with the smallest
// total (lowest index on ties); the size is added with saturation at
// 2^64-1 and the worker index and new total come back as one transfer on
// rsp. first_area clears every total before the assignment. The worker
// count written on cfg (0 acts as 1, values above 16 act as 16) selects
// the active workers; changing it keeps all totals. An area occupies the
// block through the accepting cycle, the scan that reads one total per
// cycle from the single-port total memory for each active worker, the
// last compare and the saturating write-back. The result becomes valid
// as the block returns to idle, and the next area can be accepted in
// that same cycle. A new area is accepted while the previous result
// still waits on rsp; the write-back then stalls until the result
// register is free. cfg is always ready and must only be written while
// the block is idle. Totals are zero after reset with no clearing pass.
module least_loaded_area_assigner_core (
	input logic       clk,
	input logic       arst_n,
	llaa_cfg_if.sink  cfg,
	llaa_req_if.sink  req,
	llaa_rsp_if.source rsp
);

	llaa_pkg::llaa_cmd_t cmd;

	// sequencer: owns the count register and all three handshakes
	llaa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cfg_valid (cfg.valid),
		.cfg_ready (cfg.ready),
		.cfg_count (cfg.worker_count),
		.cmd       (cmd)
	);

	// total memory, minimum tracking and result register
	llaa_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.area_size    (req.area_size),
		.first_area   (req.first_area),
		.worker_index (rsp.worker_index),
		.worker_load  (rsp.worker_load)
	);

endmodule

### rtl/core/llaa_dp.sv
// Datapath: load total memory with per-entry valid bits, running minimum,
// saturating update and result register. Depends on llaa_pkg.
module llaa_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  llaa_pkg::llaa_cmd_t cmd,
	input  llaa_pkg::size_t     area_size,
	input  logic                first_area,
	output llaa_pkg::widx_t     worker_index,
	output llaa_pkg::load_t     worker_load
);

	llaa_pkg::load_t                  mem_q [llaa_pkg::MAX_WORKERS];
	logic [llaa_pkg::MAX_WORKERS-1:0] vld_q;

	llaa_pkg::size_t size_q;
	llaa_pkg::load_t rd_data_s1;
	logic            rd_ok_s1;
	logic            rd_vld_s1;
	llaa_pkg::idx_t  rd_idx_s1;
	llaa_pkg::load_t best_q;
	llaa_pkg::idx_t  best_idx_q;
	llaa_pkg::widx_t worker_index_q;
	llaa_pkg::load_t worker_load_q;

	llaa_pkg::load_t              cur;
	logic [llaa_pkg::LOAD_W:0]    sum;
	llaa_pkg::load_t              new_load;

	// an entry never written since the last clear reads as zero
	assign cur      = rd_ok_s1 ? rd_data_s1 : '0;
	assign sum      = {1'b0, best_q} + (llaa_pkg::LOAD_W+1)'(size_q);
	assign new_load = sum[llaa_pkg::LOAD_W] ? '1 : sum[llaa_pkg::LOAD_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.upd)
			mem_q[best_idx_q] <= new_load;
		if (cmd.rd_en)
			rd_data_s1 <= mem_q[cmd.rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd_en;
			if (cmd.load && first_area)
				vld_q <= '0;
			else if (cmd.upd)
				vld_q[best_idx_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			size_q <= area_size;
		if (cmd.rd_en) begin
			rd_ok_s1  <= vld_q[cmd.rd_addr];
			rd_idx_s1 <= cmd.rd_addr;
		end
		// strict compare keeps the lowest index on ties
		if (rd_vld_s1 && (rd_idx_s1 == '0 || cur < best_q)) begin
			best_q     <= cur;
			best_idx_q <= rd_idx_s1;
		end
		if (cmd.upd) begin
			worker_index_q <= llaa_pkg::WIDX_W'(best_idx_q);
			worker_load_q  <= new_load;
		end
	end

	assign worker_index = worker_index_q;
	assign worker_load  = worker_load_q;

	a_upd_no_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd |=> worker_load_q >= $past(best_q))
		else $error("updated total below previous minimum");

endmodule

### rtl/core/llaa_ctrl.sv
// Controller: worker count register, scan sequencer and result valid flag.
// Depends on llaa_pkg.
module llaa_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  llaa_pkg::count_t     cfg_count,
	output llaa_pkg::llaa_cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_UPD   = 2'd3;

	logic [1:0]       state_q, state_d;
	llaa_pkg::idx_t   cnt_q, cnt_d;
	llaa_pkg::count_t count_q;
	logic             rsp_valid_q;
	llaa_pkg::idx_t   last_idx;
	logic             out_free;
	logic             req_fire;

	// highest active worker: zero count acts as one, large counts clamp
	always_comb begin
		if (count_q == '0)
			last_idx = '0;
		else if (32'(count_q) > llaa_pkg::MAX_WORKERS)
			last_idx = llaa_pkg::IDX_W'(llaa_pkg::MAX_WORKERS - 1);
		else
			last_idx = llaa_pkg::IDX_W'(count_q - llaa_pkg::count_t'(1));
	end

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		cmd         = '0;
		cmd.rd_addr = cnt_q;
		unique case (state_q)
			ST_IDLE: begin
				cnt_d = '0;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.rd_en = 1'b1;
				if (cnt_q == last_idx)
					state_d = ST_DRAIN;
				else
					cnt_d = cnt_q + llaa_pkg::idx_t'(1);
			end
			ST_DRAIN: begin
				state_d = ST_UPD;
			end
			ST_UPD: begin
				if (out_free) begin
					cmd.upd = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			count_q     <= llaa_pkg::COUNT_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cfg_valid && cfg_ready)
				count_q <= cfg_count;
			if (cmd.upd)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

	a_upd_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd |-> (!rsp_valid_q || rsp_ready))
		else $error("result register overwritten while held");

	a_scan_starts_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> (cmd.rd_en && cmd.rd_addr == '0))
		else $error("scan did not start at worker zero");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> cmd.rd_addr <= last_idx)
		else $error("scan read beyond active workers");

endmodule
